// ===== sv/isort_pkg.sv =====
// Shared types and constants for the insertion sorter.
package isort_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int VALUE_W   = 32;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_in_word;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      final_res;
        logic                      overflow;
    } t_out_word;

    typedef struct packed {
        logic ins;    // insert the broadcast value into the chain
        logic shift;  // move every entry one place toward cell 0
    } t_cell_ctrl;

endpackage

// ===== sv/isort_cell.sv =====
// One cell of the sorting chain: holds one entry and trades it with its neighbors.
module isort_cell
    import isort_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cell_ctrl                i_ctrl,
    input  logic signed [VALUE_W-1:0] i_ins_value,
    input  logic signed [VALUE_W-1:0] i_prev_value,
    input  logic                      i_prev_valid,
    input  logic                      i_prev_gt,
    input  logic signed [VALUE_W-1:0] i_next_value,
    input  logic                      i_next_valid,
    output logic signed [VALUE_W-1:0] o_value,
    output logic                      o_valid,
    output logic                      o_gt
);

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;
    logic                      r_valid;
    logic                      n_valid;
    logic                      gt;

    // Strictly greater, so equal values keep arrival order.
    assign gt = r_valid && (r_value > i_ins_value);

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctrl.ins) begin
            if (i_prev_gt) begin
                n_value = i_prev_value;
                n_valid = 1'b1;
            end else if (gt || (!r_valid && i_prev_valid)) begin
                n_value = i_ins_value;
                n_valid = 1'b1;
            end
        end else if (i_ctrl.shift) begin
            n_value = i_next_value;
            n_valid = i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_valid = r_valid;
    assign o_gt    = gt;

endmodule

// ===== sv/insertion_sorter_core.sv =====
// Top level of the insertion sorter: chain of sorting cells plus load/drain control.
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_word  {value, last}
//  out     | output    | o_out_valid / i_out_ready | o_out_word {sorted_value, final_res,
//          |           |                           |             overflow}
//
//  Load: one input word per cycle; the value is compared in every cell at
//  once and lands in the chain at the next edge.
//  Drain: after the word marked last, the chain shifts toward cell 0 one place
//  per accepted output word; input is held off (o_in_ready low) while draining.
//  Output stalls simply freeze the chain. Reset empties the chain.
module insertion_sorter_core
    import isort_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic r_state;
    logic n_state;
    logic r_ovf;
    logic n_ovf;

    logic signed [VALUE_W-1:0] cell_value [MAX_ITEMS];
    logic                      cell_valid [MAX_ITEMS];
    logic                      cell_gt    [MAX_ITEMS];

    t_cell_ctrl ctrl;
    logic       in_acc;
    logic       out_acc;
    logic       full;
    logic       out_last;

    // The chain is full once its top cell holds an entry.
    assign full     = cell_valid[MAX_ITEMS-1];
    assign in_acc   = i_in_valid && o_in_ready;
    assign out_acc  = o_out_valid && i_out_ready;
    // Final word: nothing stands behind cell 0.
    assign out_last = !cell_valid[1];

    assign ctrl.ins   = in_acc && !full;
    assign ctrl.shift = out_acc;

    assign o_in_ready  = (r_state == ST_LOAD);
    assign o_out_valid = (r_state == ST_DRAIN) && cell_valid[0];

    assign o_out_word.sorted_value = cell_value[0];
    assign o_out_word.final_res    = out_last;
    assign o_out_word.overflow     = r_ovf;

    // Build the chain: each cell sees its lower neighbor for insertion and its
    // upper neighbor for draining.
    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        logic signed [VALUE_W-1:0] prev_value;
        logic                      prev_valid;
        logic                      prev_gt;
        logic signed [VALUE_W-1:0] next_value;
        logic                      next_valid;

        if (g == 0) begin : g_bottom
            assign prev_value = '0;
            assign prev_valid = 1'b1;
            assign prev_gt    = 1'b0;
        end else begin : g_mid_lo
            assign prev_value = cell_value[g-1];
            assign prev_valid = cell_valid[g-1];
            assign prev_gt    = cell_gt[g-1];
        end

        if (g == MAX_ITEMS - 1) begin : g_top
            assign next_value = '0;
            assign next_valid = 1'b0;
        end else begin : g_mid_hi
            assign next_value = cell_value[g+1];
            assign next_valid = cell_valid[g+1];
        end

        isort_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (ctrl),
            .i_ins_value  (i_in_word.value),
            .i_prev_value (prev_value),
            .i_prev_valid (prev_valid),
            .i_prev_gt    (prev_gt),
            .i_next_value (next_value),
            .i_next_valid (next_valid),
            .o_value      (cell_value[g]),
            .o_valid      (cell_valid[g]),
            .o_gt         (cell_gt[g])
        );
    end

    // Load until the last word arrives, drain until the final word leaves.
    always_comb begin
        n_state = r_state;
        n_ovf   = r_ovf;
        unique case (r_state)
            ST_LOAD: begin
                if (in_acc && full) begin
                    n_ovf = 1'b1;  // drop the value, flag the batch
                end
                if (in_acc && i_in_word.last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_acc && out_last) begin
                    n_state = ST_LOAD;
                    n_ovf   = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovf   <= n_ovf;
        end
    end

endmodule
